@@ design/cas_pkg.sv @@
// ----------------------------------------------------------------------------
// cas_pkg
// Shared constants for the CNF assignment simplifier: defaults, field widths,
// request kinds and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package cas_pkg;

    localparam int MAX_CLAUSES_DEF = 256;
    localparam int MAX_TERMS_DEF   = 8;

    localparam int LIT_W       = 9;
    localparam int TDATA_IN_W  = 32;
    localparam int TUSER_IN_W  = 2;
    localparam int TDATA_OUT_W = 8;
    localparam int CFG_W       = 9;

    // request kinds (tuser)
    localparam logic [1:0] KIND_APPEND = 2'd0;
    localparam logic [1:0] KIND_ASSIGN = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;

    // status codes
    localparam logic [1:0] ST_UNSOLVED = 2'd0;
    localparam logic [1:0] ST_SOLVED   = 2'd1;
    localparam logic [1:0] ST_INCONS   = 2'd2;

endpackage

`default_nettype wire

@@ design/cas_ram.sv @@
// ----------------------------------------------------------------------------
// cas_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module cas_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 2048,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ design/cnf_assignment_simplifier_top.sv @@
// ----------------------------------------------------------------------------
// cnf_assignment_simplifier_top
// CNF clause store with clause simplification on variable assignment.
// ----------------------------------------------------------------------------
// Request handling: append writes its literal in S_APP; clear and unused kinds
//   go straight to S_DONE; assign visits each clause in S_CL and S_CNT and, unless
//   it is empty or phase is 0, scans one literal per cycle in S_FIND, then S_CMP to compact.
// One request at a time; a finished result may wait in the output register.
// Reset: synchronous; status unsolved, clause_count 0, term counts read zero
//   at once through per-clause valid bits (no clearing pass).
`default_nettype none

module cnf_assignment_simplifier_top #(
    parameter int MAX_CLAUSES = cas_pkg::MAX_CLAUSES_DEF,
    parameter int MAX_TERMS   = cas_pkg::MAX_TERMS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // configuration: clause_count
    input  wire logic                           i_cfg_we,
    input  wire logic [cas_pkg::CFG_W-1:0]      i_cfg_wdata,
    // requests
    input  wire logic                           i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // clause_index[7:0], start_clause[8], literal[17:9], variable[25:18],
    // phase[27:26], zero[31:28]
    input  wire logic [cas_pkg::TDATA_IN_W-1:0] i_s_axis_tdata,
    // kind[1:0]
    input  wire logic [cas_pkg::TUSER_IN_W-1:0] i_s_axis_tuser,
    // results
    output logic                                o_m_axis_tvalid,
    input  wire logic                           i_m_axis_tready,
    // status[1:0], load_overflow[2], zero[7:3]
    output logic [cas_pkg::TDATA_OUT_W-1:0]     o_m_axis_tdata
);

    import cas_pkg::*;

    localparam int DEPTH = MAX_CLAUSES * MAX_TERMS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CIW   = (MAX_CLAUSES > 1) ? $clog2(MAX_CLAUSES) : 1;
    localparam int CNW   = $clog2(MAX_CLAUSES + 1);
    localparam int TCW   = $clog2(MAX_TERMS + 1);
    localparam int CMPW  = (CNW > CFG_W) ? CNW : CFG_W;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_APP  = 7'b0000010,
        S_CL   = 7'b0000100,
        S_CNT  = 7'b0001000,
        S_FIND = 7'b0010000,
        S_CMP  = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    logic [1:0]       r_status, n_status;
    logic [CFG_W-1:0] r_cc;
    logic             r_out_valid;
    logic [1:0]       r_out_status;
    logic             r_out_ovf;
    logic             r_tc_vld [MAX_CLAUSES];

    logic             r_start, n_start;
    logic [LIT_W-1:0] r_lit, n_lit;
    logic [7:0]       r_var, n_var;
    logic [1:0]       r_phase, n_phase;
    logic             r_ovf, n_ovf;
    logic [CNW-1:0]   r_i, n_i;
    logic [AW-1:0]    r_base, n_base;
    logic [TCW-1:0]   r_cnt, n_cnt;
    logic [TCW-1:0]   r_j, n_j;
    logic [TCW-1:0]   r_k, n_k;
    logic             r_all_zero, n_all_zero;
    logic [CIW-1:0]   r_tc_addr, n_tc_addr;

    logic             lit_we;
    logic [AW-1:0]    lit_waddr, lit_raddr;
    logic [LIT_W-1:0] lit_wdata, lit_rdata;
    logic             tc_we;
    logic [CIW-1:0]   tc_waddr, tc_raddr;
    logic [TCW-1:0]   tc_wdata, tc_rdata;
    logic             vld_set, vld_clr, vld_clr_all, load_out;

    logic             in_acc;
    logic [7:0]       in_cidx;
    logic [1:0]       in_kind;
    logic [CMPW-1:0]  cc_ext;
    logic [CNW-1:0]   n_lim;
    logic [TCW-1:0]   tc_cur;
    logic [TCW-1:0]   j_nxt;
    logic [LIT_W-1:0] lit_mag;
    logic             hit, same_sign;

    assign in_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign in_cidx = i_s_axis_tdata[7:0];
    assign in_kind = i_s_axis_tuser[1:0];

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(TDATA_OUT_W - 3){1'b0}}, r_out_ovf, r_out_status};

    // clauses scanned: min(clause_count, MAX_CLAUSES)
    assign cc_ext = CMPW'(r_cc);
    assign n_lim  = (cc_ext >= CMPW'(MAX_CLAUSES)) ? CNW'(MAX_CLAUSES) : CNW'(r_cc);

    assign tc_cur  = r_tc_vld[r_tc_addr] ? tc_rdata : '0;
    assign j_nxt   = r_j + 1'b1;
    // literal zero has magnitude zero and never matches a variable
    assign lit_mag   = lit_rdata[LIT_W-1] ? (~lit_rdata + 1'b1) : lit_rdata;
    assign hit       = (lit_rdata != '0) && (lit_mag == LIT_W'(r_var));
    assign same_sign = (!lit_rdata[LIT_W-1]) == (r_phase == 2'b01);

    cas_ram #(
        .WIDTH (LIT_W),
        .DEPTH (DEPTH)
    ) u_lit_ram (
        .i_clk   (i_clk),
        .i_we    (lit_we),
        .i_waddr (lit_waddr),
        .i_wdata (lit_wdata),
        .i_raddr (lit_raddr),
        .o_rdata (lit_rdata)
    );

    cas_ram #(
        .WIDTH (TCW),
        .DEPTH (MAX_CLAUSES)
    ) u_tc_ram (
        .i_clk   (i_clk),
        .i_we    (tc_we),
        .i_waddr (tc_waddr),
        .i_wdata (tc_wdata),
        .i_raddr (tc_raddr),
        .o_rdata (tc_rdata)
    );

    always_comb begin
        n_state    = r_state;
        n_status   = r_status;
        n_start    = r_start;
        n_lit      = r_lit;
        n_var      = r_var;
        n_phase    = r_phase;
        n_ovf      = r_ovf;
        n_i        = r_i;
        n_base     = r_base;
        n_cnt      = r_cnt;
        n_j        = r_j;
        n_k        = r_k;
        n_all_zero = r_all_zero;
        n_tc_addr  = r_tc_addr;

        lit_we      = 1'b0;
        lit_waddr   = r_base + AW'(r_k);
        lit_wdata   = lit_rdata;
        lit_raddr   = r_base + AW'(j_nxt);
        tc_we       = 1'b0;
        tc_waddr    = r_tc_addr;
        tc_wdata    = r_k;
        tc_raddr    = r_i[CIW-1:0];
        vld_set     = 1'b0;
        vld_clr     = 1'b0;
        vld_clr_all = 1'b0;
        load_out    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_start = i_s_axis_tdata[8];
                    n_lit   = i_s_axis_tdata[17:9];
                    n_var   = i_s_axis_tdata[25:18];
                    n_phase = i_s_axis_tdata[27:26];
                    n_ovf   = 1'b0;
                    unique case (in_kind)
                        KIND_APPEND: begin
                            if (CMPW'(in_cidx) >= CMPW'(MAX_CLAUSES)) begin
                                n_ovf   = 1'b1;
                                n_state = S_DONE;
                            end else begin
                                tc_raddr  = CIW'(in_cidx);
                                n_tc_addr = CIW'(in_cidx);
                                n_state   = S_APP;
                            end
                        end
                        KIND_ASSIGN: begin
                            n_i        = '0;
                            n_base     = '0;
                            n_all_zero = 1'b1;
                            n_state    = S_CL;
                        end
                        KIND_CLEAR: begin
                            vld_clr_all = 1'b1;
                            n_status    = ST_UNSOLVED;
                            n_state     = S_DONE;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_APP: begin
                // a restarting append begins from an empty clause
                if (!r_start && (tc_cur >= TCW'(MAX_TERMS))) begin
                    n_ovf = 1'b1;
                end else begin
                    lit_we    = 1'b1;
                    lit_waddr = AW'(r_tc_addr) * AW'(MAX_TERMS)
                                + AW'(r_start ? '0 : tc_cur);
                    lit_wdata = r_lit;
                    tc_we     = 1'b1;
                    tc_wdata  = (r_start ? '0 : tc_cur) + 1'b1;
                    vld_set   = 1'b1;
                end
                n_state = S_DONE;
            end
            S_CL: begin
                if (r_i == n_lim) begin
                    if (r_all_zero) begin
                        n_status = ST_SOLVED;
                    end
                    n_state = S_DONE;
                end else begin
                    n_tc_addr = r_i[CIW-1:0];
                    n_state   = S_CNT;
                end
            end
            S_CNT: begin
                n_cnt = tc_cur;
                if (tc_cur == '0) begin
                    n_i     = r_i + 1'b1;
                    n_base  = r_base + AW'(MAX_TERMS);
                    n_state = S_CL;
                end else if (r_phase == 2'b00) begin
                    n_all_zero = 1'b0;
                    n_i        = r_i + 1'b1;
                    n_base     = r_base + AW'(MAX_TERMS);
                    n_state    = S_CL;
                end else begin
                    lit_raddr = r_base;
                    n_j       = '0;
                    n_state   = S_FIND;
                end
            end
            S_FIND: begin
                // read data is literal r_j; literal r_j+1 is being fetched
                if (hit) begin
                    if (same_sign) begin
                        vld_clr = 1'b1;
                        n_i     = r_i + 1'b1;
                        n_base  = r_base + AW'(MAX_TERMS);
                        n_state = S_CL;
                    end else if (r_cnt == TCW'(1)) begin
                        n_status = ST_INCONS;
                        n_state  = S_DONE;
                    end else begin
                        // nothing before r_j matches, compaction starts here
                        n_j     = j_nxt;
                        n_k     = r_j;
                        n_state = S_CMP;
                    end
                end else if (j_nxt == r_cnt) begin
                    n_all_zero = 1'b0;
                    n_i        = r_i + 1'b1;
                    n_base     = r_base + AW'(MAX_TERMS);
                    n_state    = S_CL;
                end else begin
                    n_j = j_nxt;
                end
            end
            S_CMP: begin
                if (r_j == r_cnt) begin
                    tc_we   = 1'b1;
                    vld_set = 1'b1;
                    if (r_k != '0) begin
                        n_all_zero = 1'b0;
                    end
                    n_i     = r_i + 1'b1;
                    n_base  = r_base + AW'(MAX_TERMS);
                    n_state = S_CL;
                end else begin
                    // write slot r_k trails the read address
                    if (!hit) begin
                        lit_we = 1'b1;
                        n_k    = r_k + 1'b1;
                    end
                    n_j = j_nxt;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_status    <= ST_UNSOLVED;
            r_cc        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
            if (i_cfg_we) begin
                r_cc <= i_cfg_wdata;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < MAX_CLAUSES; c++) begin
                r_tc_vld[c] <= 1'b0;
            end
        end else if (vld_clr_all) begin
            for (int c = 0; c < MAX_CLAUSES; c++) begin
                r_tc_vld[c] <= 1'b0;
            end
        end else if (vld_set) begin
            r_tc_vld[r_tc_addr] <= 1'b1;
        end else if (vld_clr) begin
            r_tc_vld[r_tc_addr] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_start    <= n_start;
        r_lit      <= n_lit;
        r_var      <= n_var;
        r_phase    <= n_phase;
        r_ovf      <= n_ovf;
        r_i        <= n_i;
        r_base     <= n_base;
        r_cnt      <= n_cnt;
        r_j        <= n_j;
        r_k        <= n_k;
        r_all_zero <= n_all_zero;
        r_tc_addr  <= n_tc_addr;
        if (load_out) begin
            r_out_status <= r_status;
            r_out_ovf    <= r_ovf;
        end
    end

endmodule

`default_nettype wire

@@ tb/sv/cnf_simplifier_checker.sv @@
// ----------------------------------------------------------------------------
// cnf_simplifier_checker
// Watches the request, result and configuration ports of the CNF assignment
// simplifier, keeps its own copy of the clause store, predicts the status and
// overflow flag of every request and compares them with the results in order.
// ----------------------------------------------------------------------------
`default_nettype none

module cnf_simplifier_checker #(
    parameter int MAX_CLAUSES = cas_pkg::MAX_CLAUSES_DEF,
    parameter int MAX_TERMS   = cas_pkg::MAX_TERMS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [cas_pkg::CFG_W-1:0]       i_cfg_wdata,
    input  wire logic                            i_req_valid,
    input  wire logic                            i_req_ready,
    // clause_index[7:0], start_clause[8], literal[17:9], variable[25:18],
    // phase[27:26], zero[31:28]
    input  wire logic [cas_pkg::TDATA_IN_W-1:0]  i_req_data,
    // kind[1:0]
    input  wire logic [cas_pkg::TUSER_IN_W-1:0]  i_req_kind,
    input  wire logic                            i_res_valid,
    input  wire logic                            i_res_ready,
    // status[1:0], load_overflow[2], zero[7:3]
    input  wire logic [cas_pkg::TDATA_OUT_W-1:0] i_res_data,
    output int                                   o_mismatches,
    output int                                   o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import cas_pkg::*;

    typedef struct packed {
        logic [1:0] status;
        logic       overflow;
    } t_outcome;

    logic signed [LIT_W-1:0] literals [MAX_CLAUSES][MAX_TERMS];
    int                      terms [MAX_CLAUSES];
    logic [1:0]              status_q;
    logic [CFG_W-1:0]        clauses_in_use;
    t_outcome                outcomes_due [$];
    int                      mismatch_count = 0;

    function automatic int literal_magnitude(input logic signed [LIT_W-1:0] lit);
        int v;
        v = lit;
        return (v < 0) ? -v : v;
    endfunction

    // Scan clauses in order; the first literal of the variable in each clause
    // decides between satisfied, conflict on a unit clause, or removal.
    function automatic void apply_assignment(input logic [7:0] var_idx,
                                             input logic [1:0] ph);
        int  sense, scan_len, cnt, kept, i, j, l;
        bit  decided, conflict, all_empty;
        logic signed [LIT_W-1:0] lit;
        sense    = ($signed(ph) > 0) ? 1 : (($signed(ph) < 0) ? -1 : 0);
        scan_len = (int'(clauses_in_use) > MAX_CLAUSES) ? MAX_CLAUSES
                                                        : int'(clauses_in_use);
        conflict = 1'b0;
        for (i = 0; i < scan_len && !conflict; i++) begin
            cnt     = (terms[i] > MAX_TERMS) ? MAX_TERMS : terms[i];
            decided = 1'b0;
            for (j = 0; j < cnt && !decided; j++) begin
                lit = literals[i][j];
                if (sense != 0 && lit != 0 && literal_magnitude(lit) == int'(var_idx)) begin
                    decided = 1'b1;
                    if ((lit > 0) == (sense > 0)) begin
                        terms[i] = 0;
                    end else if (cnt == 1) begin
                        conflict = 1'b1;
                    end else begin
                        kept = 0;
                        for (l = 0; l < cnt; l++) begin
                            if (literal_magnitude(literals[i][l]) != int'(var_idx)) begin
                                literals[i][kept] = literals[i][l];
                                kept++;
                            end
                        end
                        terms[i] = kept;
                    end
                end
            end
        end
        if (conflict) begin
            status_q = ST_INCONS;
        end else begin
            // solved check may overwrite an earlier inconsistent status
            all_empty = 1'b1;
            for (i = 0; i < scan_len; i++) begin
                if (terms[i] != 0) all_empty = 1'b0;
            end
            if (all_empty) status_q = ST_SOLVED;
        end
    endfunction

    function automatic t_outcome predict_request(input logic [TUSER_IN_W-1:0] kind,
                                                 input logic [TDATA_IN_W-1:0] data);
        logic [7:0]  cidx;
        logic        restart;
        logic [8:0]  lit_bits;
        logic [7:0]  var_idx;
        logic [1:0]  ph;
        t_outcome    res;
        cidx     = data[7:0];
        restart  = data[8];
        lit_bits = data[17:9];
        var_idx  = data[25:18];
        ph       = data[27:26];
        res.overflow = 1'b0;
        case (kind)
            KIND_APPEND: begin
                if (int'(cidx) >= MAX_CLAUSES) begin
                    res.overflow = 1'b1;
                end else begin
                    if (restart) terms[cidx] = 0;
                    if (terms[cidx] >= MAX_TERMS) begin
                        res.overflow = 1'b1;
                    end else begin
                        literals[cidx][terms[cidx]] = lit_bits;
                        terms[cidx]++;
                    end
                end
            end
            KIND_ASSIGN: apply_assignment(var_idx, ph);
            KIND_CLEAR: begin
                for (int i = 0; i < MAX_CLAUSES; i++) terms[i] = 0;
                status_q = ST_UNSOLVED;
            end
            default: ;
        endcase
        res.status = status_q;
        return res;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_outcome want;
        t_outcome got;
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_CLAUSES; i++) terms[i] = 0;
            status_q       = ST_UNSOLVED;
            clauses_in_use = '0;
            outcomes_due.delete();
        end else begin
            if (i_cfg_we) clauses_in_use = i_cfg_wdata;
            if (i_res_valid && i_res_ready) begin
                got.status   = i_res_data[1:0];
                got.overflow = i_res_data[2];
                if (outcomes_due.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected result: status %0d overflow %0d",
                             $time, got.status, got.overflow);
                end else begin
                    want = outcomes_due.pop_front();
                    if (got.status !== want.status) begin
                        mismatch_count++;
                        $display("%0t: status expected %0d, actual %0d",
                                 $time, want.status, got.status);
                    end
                    if (got.overflow !== want.overflow) begin
                        mismatch_count++;
                        $display("%0t: load_overflow expected %0d, actual %0d",
                                 $time, want.overflow, got.overflow);
                    end
                end
            end
            if (i_req_valid && i_req_ready)
                outcomes_due.push_back(predict_request(i_req_kind, i_req_data));
        end
        o_outstanding <= outcomes_due.size();
        o_mismatches  <= mismatch_count;
    end

endmodule

`default_nettype wire

@@ tb/sv/tb_cnf_assignment_simplifier_top.sv @@
// ----------------------------------------------------------------------------
// tb_cnf_assignment_simplifier_top
// Drives the CNF assignment simplifier with a directed sequence and then with
// random phases of clause loading and assignments under several clause counts,
// with random stalls on both sides and one long result back-pressure period.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_cnf_assignment_simplifier_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cas_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam logic [1:0] PH_TRUE     = 2'b01;
    localparam logic [1:0] PH_FALSE    = 2'b11;
    localparam logic [1:0] PH_FALSE2   = 2'b10;
    localparam logic [1:0] PH_NONE     = 2'b00;

    localparam int REQUEST_TARGET  = 290;
    localparam int HOLD_CYCLES     = 300;
    // loads here keep every scan far below the worst case
    localparam int WATCHDOG_CYCLES = 3_000_000;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [CFG_W-1:0]        i_cfg_wdata;
    logic                    i_s_axis_tvalid;
    logic                    o_s_axis_tready;
    logic [TDATA_IN_W-1:0]   i_s_axis_tdata;
    logic [TUSER_IN_W-1:0]   i_s_axis_tuser;
    logic                    o_m_axis_tvalid;
    logic                    i_m_axis_tready;
    logic [TDATA_OUT_W-1:0]  o_m_axis_tdata;

    int         mismatches;
    int         outstanding;
    int         requests_sent = 0;
    int         holds_asked   = 0;
    int         holds_done    = 0;
    int         cycle_count   = 0;
    bit         steady        = 1'b0;
    logic [7:0] vars_in_play [4];

    cnf_assignment_simplifier_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    cnf_simplifier_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_req_valid   (i_s_axis_tvalid),
        .i_req_ready   (o_s_axis_tready),
        .i_req_data    (i_s_axis_tdata),
        .i_req_kind    (i_s_axis_tuser),
        .i_res_valid   (o_m_axis_tvalid),
        .i_res_ready   (i_m_axis_tready),
        .i_res_data    (o_m_axis_tdata),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_count < WATCHDOG_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb_cnf_assignment_simplifier_top: errors");
        $finish;
    end

    // result side: random stalls, plus a long hold-off when asked for
    initial begin
        i_m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (holds_done != holds_asked) begin
                holds_done = holds_asked;
                i_m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            if (steady) i_m_axis_tready <= 1'b1;
            else        i_m_axis_tready <= ($urandom_range(0, 99) >= 17);
        end
    end

    task automatic offer(input logic [1:0] kind, input logic [7:0] cidx,
                         input logic restart, input logic [8:0] lit,
                         input logic [7:0] var_idx, input logic [1:0] ph);
        if (!steady && $urandom_range(0, 99) < 17) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {4'b0, ph, var_idx, lit, restart, cidx};
        i_s_axis_tuser  <= kind;
        do @(posedge i_clk); while (!o_s_axis_tready);
        if (kind != KIND_UNUSED) requests_sent++;
    endtask

    task automatic append_literal(input logic [7:0] cidx, input logic restart,
                                  input logic [8:0] lit);
        offer(KIND_APPEND, cidx, restart, lit, 8'($urandom), 2'($urandom));
    endtask

    task automatic assign_value(input logic [7:0] var_idx, input logic [1:0] ph);
        offer(KIND_ASSIGN, 8'($urandom), 1'($urandom), 9'($urandom), var_idx, ph);
    endtask

    // clear or unused kind: the data fields carry noise
    task automatic offer_bare(input logic [1:0] kind);
        offer(kind, 8'($urandom), 1'($urandom), 9'($urandom), 8'($urandom),
              2'($urandom));
    endtask

    task automatic configure(input logic [CFG_W-1:0] value);
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic logic [8:0] pick_literal();
        int         r;
        logic [7:0] v;
        r = $urandom_range(0, 99);
        if (r < 78) begin
            v = vars_in_play[$urandom_range(0, 3)];
            return $urandom_range(0, 1) ? -{1'b0, v} : {1'b0, v};
        end else if (r < 86) begin
            return 9'd0;
        end else if (r < 92) begin
            return 9'h100;
        end
        return 9'($urandom_range(0, 511));
    endfunction

    function automatic logic [7:0] pick_variable();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) return vars_in_play[$urandom_range(0, 3)];
        if (r < 90) return 8'd0;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [1:0] pick_phase();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return PH_TRUE;
        if (r < 75) return PH_FALSE;
        if (r < 90) return PH_FALSE2;
        return PH_NONE;
    endfunction

    initial begin : stimulus
        int         phase_no;
        int         clauses;
        int         span;
        int         near_span;
        int         len;
        int         noise;
        logic [7:0] cidx;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // no clauses in use: an assignment finds everything satisfied
        offer_bare(KIND_UNUSED);
        assign_value(8'd1, PH_TRUE);
        offer_bare(KIND_CLEAR);

        configure(9'd2);
        append_literal(8'd0, 1'b1, 9'd3);
        append_literal(8'd0, 1'b0, -9'sd7);
        append_literal(8'd0, 1'b0, 9'd0);
        append_literal(8'd0, 1'b0, -9'sd3);
        append_literal(8'd0, 1'b0, 9'd255);
        append_literal(8'd0, 1'b0, 9'h100);
        append_literal(8'd0, 1'b0, 9'd3);
        append_literal(8'd0, 1'b0, 9'd1);
        append_literal(8'd0, 1'b0, 9'd5);     // clause full, dropped
        append_literal(8'd1, 1'b1, -9'sd3);
        assign_value(8'd0, PH_TRUE);
        assign_value(8'd3, PH_NONE);
        assign_value(8'd3, PH_FALSE2);        // compacts clause 0, satisfies 1
        append_literal(8'd1, 1'b1, 9'd9);
        assign_value(8'd9, PH_FALSE);         // unit conflict
        assign_value(8'd7, PH_FALSE);
        append_literal(8'd1, 1'b1, -9'sd9);
        assign_value(8'd9, PH_FALSE);         // all empty again: solved

        // count past the store size
        configure(9'd511);
        assign_value(8'd2, PH_TRUE);
        offer_bare(KIND_UNUSED);

        phase_no = 0;
        while (requests_sent < REQUEST_TARGET) begin
            phase_no++;
            if (phase_no == 2)                     clauses = 256;
            else if (phase_no == 4)                clauses = 0;
            else if (phase_no == 6)                clauses = 300;
            else if ($urandom_range(0, 9) == 0)    clauses = $urandom_range(17, 511);
            else                                   clauses = $urandom_range(1, 12);
            configure(clauses[8:0]);
            steady = (phase_no == 3);
            if (phase_no == 5) holds_asked++;
            for (int k = 0; k < 4; k++) vars_in_play[k] = 8'($urandom_range(1, 255));
            if ($urandom_range(0, 1) == 0) vars_in_play[0] = 8'($urandom_range(1, 7));
            if ($urandom_range(0, 1) == 0) offer_bare(KIND_CLEAR);

            span      = (clauses > 256) ? 256 : clauses;
            near_span = (span == 0) ? 4 : ((span > 12) ? 12 : span);
            repeat ($urandom_range(1, 2)) begin
                repeat ($urandom_range(2, 6)) begin
                    if (span > 12 && $urandom_range(0, 3) == 0)
                        cidx = 8'($urandom_range(0, span - 1));
                    else
                        cidx = 8'($urandom_range(0, near_span - 1));
                    len = $urandom_range(1, 10);
                    for (int k = 0; k < len; k++)
                        append_literal(cidx, (k == 0) && ($urandom_range(0, 9) != 0),
                                       pick_literal());
                end
                repeat ($urandom_range(2, 5)) begin
                    noise = $urandom_range(0, 99);
                    if (noise < 6)
                        offer_bare(KIND_UNUSED);
                    else if (noise < 16)
                        append_literal(8'($urandom), 1'($urandom), 9'($urandom));
                    else if (noise < 19)
                        offer_bare(KIND_CLEAR);
                    assign_value(pick_variable(), pick_phase());
                end
            end
        end

        steady = 1'b0;
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0)
            $display("tb_cnf_assignment_simplifier_top: clean");
        else
            $display("tb_cnf_assignment_simplifier_top: errors");
        $finish;
    end

endmodule

`default_nettype wire
